FILE: design/atrp_pkg.sv
package atrp_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0] half_t;

	// Relocation kinds
	typedef enum logic [2:0] {
		OP_ABS32     = 3'd0,
		OP_THM_CALL  = 3'd1,
		OP_THM_JUMP  = 3'd2,
		OP_MOVW      = 3'd3,
		OP_MOVT      = 3'd4
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_KIND   = 2'd1,
		STATUS_UNRESOLVED = 2'd2
	} status_t;

	localparam word_t INVALID_SYMBOL = 32'hFFFF_FFFF;
	localparam half_t MOV_UP_KEEP    = 16'hFBF0;
	localparam half_t MOV_DN_KEEP    = 16'h8F00;
	localparam half_t BR_HI_KEEP     = 16'hF800;
	localparam half_t BR_LO_KEEP     = 16'hC000;

	// Flags that steer the branch fixup
	typedef struct packed {
		logic call;     // BL kind: ARM target turns into BLX
		logic thumb;    // target address bit 0
		logic sym_bit1; // target address bit 1
	} branch_ctl_t;

	// Decode the 25-bit BL/B.W offset and sign extend it to 32 bits
	function automatic word_t decode_offset(input half_t hi, input half_t lo);
		logic s;
		logic i1;
		logic i2;
		s  = hi[10];
		i1 = ~(lo[13] ^ s);
		i2 = ~(lo[11] ^ s);
		return {{7{s}}, s, i1, i2, hi[9:0], lo[10:0], 1'b0};
	endfunction

	// Add the symbol to a MOVW/MOVT imm16 and re-encode the chosen half
	function automatic word_t fix_mov(input word_t word, input word_t sym, input logic top);
		half_t up;
		half_t dn;
		half_t imm;
		word_t sum;
		half_t v;
		up  = word[15:0];
		dn  = word[31:16];
		imm = {up[3:0], up[10], dn[14:12], dn[7:0]};
		sum = sym + {16'd0, imm};
		v   = top ? sum[31:16] : sum[15:0];
		up  = (up & MOV_UP_KEEP) | {5'd0, v[11], 6'd0, v[15:12]};
		dn  = (dn & MOV_DN_KEEP) | {1'b0, v[10:8], 4'd0, v[7:0]};
		return {dn, up};
	endfunction

endpackage

FILE: design/atrp_branch.sv
module atrp_branch (
	input  atrp_pkg::word_t       site_word,
	input  atrp_pkg::word_t       base,
	input  atrp_pkg::word_t       d_sym,
	input  atrp_pkg::word_t       d_tramp,
	input  atrp_pkg::branch_ctl_t ctl,
	output atrp_pkg::word_t       word,
	output logic                  redirect
);
	import atrp_pkg::*;

	logic  make_blx;
	word_t sum_sym;
	word_t sum_tramp;
	word_t rnd_sym;
	word_t rnd_tramp;
	word_t off_sym;
	word_t off_tramp;
	word_t off;
	logic  in_range;
	logic  s;
	logic  j1;
	logic  j2;
	half_t hi;
	half_t lo;

	assign make_blx = ~ctl.thumb & ctl.call;

	// Offsets to the symbol and to the stub, rounded up to 4 for BLX
	assign sum_sym   = base + d_sym;
	assign sum_tramp = base + d_tramp;
	assign rnd_sym   = sum_sym + 32'd3;
	assign rnd_tramp = sum_tramp + 32'd3;
	assign off_sym   = make_blx ? {rnd_sym[31:2], 2'b00} : sum_sym;
	assign off_tramp = make_blx ? {rnd_tramp[31:2], 2'b00} : sum_tramp;

	// Reachable when the offset fits in 25 signed bits
	assign in_range = (off_sym[31:24] == 8'h00) || (off_sym[31:24] == 8'hFF);

	// Go through the stub unless the target is Thumb and in range, or a call to a word-aligned ARM target can use BLX
	assign redirect = (~ctl.thumb | ~in_range) & (ctl.thumb | ctl.sym_bit1 | ~ctl.call);
	assign off      = redirect ? off_tramp : off_sym;

	// Re-encode the offset into the two halfwords
	always_comb begin
		s  = off[24];
		j1 = s ^ ~off[23];
		j2 = s ^ ~off[22];
		hi = (site_word[15:0] & BR_HI_KEEP) | {5'd0, s, off[21:12]};
		lo = (site_word[31:16] & BR_LO_KEEP) | {2'b00, j1, ~make_blx, j2, off[11:1]};
		word = {lo, hi};
	end

endmodule

FILE: design/arm_thumb_relocation_patcher.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// request  | in_valid/in_ready  | opcode, site_word, site_address, symbol_address,
//          |                    | trampoline_address
// result   | out_valid/out_ready| patched_word, status, used_trampoline
//
// One request is taken every cycle while the pipeline advances; a held result stalls it.
// Stage 1 registers the request, stage 2 decodes and forms the differences, stage 3
// adds the branch offset, picks the target and re-encodes into the result register.
// All stages advance together whenever the result register is empty or being taken,
// so in_ready follows out_ready in the same cycle. Reset clears only the valid bits.
module arm_thumb_relocation_patcher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        opcode,
	input  atrp_pkg::word_t   site_word,
	input  atrp_pkg::word_t   site_address,
	input  atrp_pkg::word_t   symbol_address,
	input  atrp_pkg::word_t   trampoline_address,
	output logic              out_valid,
	input  logic              out_ready,
	output atrp_pkg::word_t   patched_word,
	output logic [1:0]        status,
	output logic              used_trampoline
);
	import atrp_pkg::*;

	logic advance;

	logic        valid_s1;
	logic [2:0]  opcode_s1;
	word_t       word_s1;
	word_t       site_s1;
	word_t       sym_s1;
	word_t       tramp_s1;

	logic        valid_s2;
	word_t       word_s2;
	word_t       pre_word_s2;
	word_t       base_s2;
	word_t       d_sym_s2;
	word_t       d_tramp_s2;
	branch_ctl_t ctl_s2;
	logic        is_branch_s2;
	status_t     status_s2;

	logic        valid_s3;
	word_t       word_s3;
	status_t     status_s3;
	logic        via_s3;

	word_t       pre_word_c;
	logic        is_branch_c;
	status_t     status_c;
	word_t       br_word;
	logic        br_redirect;

	// Advance the whole pipeline unless the result register is held
	assign advance  = ~valid_s3 | out_ready;
	assign in_ready = advance;

	// Stage 1: register the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			opcode_s1 <= opcode;
			word_s1   <= site_word;
			site_s1   <= site_address;
			sym_s1    <= symbol_address;
			tramp_s1  <= trampoline_address;
		end
	end

	// Decode the kind and form the non-branch results
	always_comb begin
		pre_word_c  = word_s1;
		is_branch_c = 1'b0;
		status_c    = STATUS_OK;
		if (sym_s1 == INVALID_SYMBOL) begin
			status_c = STATUS_UNRESOLVED;
		end else begin
			unique case (opcode_s1) inside
				OP_ABS32:    pre_word_c  = word_s1 + sym_s1;
				OP_THM_CALL,
				OP_THM_JUMP: is_branch_c = 1'b1;
				OP_MOVW:     pre_word_c  = fix_mov(word_s1, sym_s1, 1'b0);
				OP_MOVT:     pre_word_c  = fix_mov(word_s1, sym_s1, 1'b1);
				default:     status_c    = STATUS_BAD_KIND;
			endcase
		end
	end

	// Stage 2: decoded offset, differences and kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2         <= word_s1;
			pre_word_s2     <= pre_word_c;
			base_s2         <= decode_offset(word_s1[15:0], word_s1[31:16]);
			d_sym_s2        <= sym_s1 - site_s1;
			d_tramp_s2      <= tramp_s1 - site_s1;
			ctl_s2.call     <= (opcode_s1 == OP_THM_CALL);
			ctl_s2.thumb    <= sym_s1[0];
			ctl_s2.sym_bit1 <= sym_s1[1];
			is_branch_s2    <= is_branch_c;
			status_s2       <= status_c;
		end
	end

	atrp_branch u_branch (
		.site_word (word_s2),
		.base      (base_s2),
		.d_sym     (d_sym_s2),
		.d_tramp   (d_tramp_s2),
		.ctl       (ctl_s2),
		.word      (br_word),
		.redirect  (br_redirect)
	);

	// Stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s3   <= is_branch_s2 ? br_word : pre_word_s2;
			status_s3 <= status_s2;
			via_s3    <= is_branch_s2 & br_redirect;
		end
	end

	assign out_valid       = valid_s3;
	assign patched_word    = word_s3;
	assign status          = status_s3;
	assign used_trampoline = via_s3;

	// Only a patched branch may go through the stub
	a_via_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_trampoline |-> status == STATUS_OK)
		else $error("trampoline flagged on a failed relocation");

	// A failed relocation is never routed to the branch path
	a_fail_not_branch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != STATUS_OK |-> !is_branch_s2)
		else $error("failed relocation marked as branch");

	// A held result stalls the inner stages too
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(valid_s2) && $stable(valid_s1))
		else $error("inner stage moved during stall");

endmodule
